// ===== rtl/msu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msu_pkg;

  localparam int MSU_WIDTH = 16;

  // operation codes
  localparam logic [1:0] OP_INVERSE = 2'd0;
  localparam logic [1:0] OP_ZERODIV = 2'd1;
  localparam logic [1:0] OP_SQRT    = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic [MSU_WIDTH-1:0] value;
  } msu_in_t;

  typedef struct packed {
    logic [MSU_WIDTH-1:0] answer;
    logic                 found;
  } msu_out_t;

endpackage

`default_nettype wire

// ===== rtl/msu_addmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Modular adder: (x + y + cin) mod m, valid while x + y + cin < 2*m.
module msu_addmod #(
  parameter int WIDTH = msu_pkg::MSU_WIDTH
) (
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic             cin,
  input  wire logic [WIDTH-1:0] m,
  output logic      [WIDTH-1:0] sum_mod
);

  logic [WIDTH:0] sum;
  logic [WIDTH:0] diff;

  assign sum  = {1'b0, x} + {1'b0, y} + {{WIDTH{1'b0}}, cin};
  assign diff = sum - {1'b0, m};

  // Subtract the modulus once when the raw sum reaches it.
  assign sum_mod = (sum >= {1'b0, m}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

endmodule

`default_nettype wire

// ===== rtl/modular_search_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_stall  msu_in_t  (operation, value)
// out_      output     out_valid/out_stall msu_out_t (answer, found)
// cfg_      input      cfg_valid/cfg_ready modulus, MSU_WIDTH bits
//
// Sequence from acceptance to the result word: inverse and zero divisor
// reduce the operand mod m bit-serially over its MSU_WIDTH bits, then test
// the candidates in turn (up to m-1), then finish. Square root alternates a
// test and a step state over candidates from 2 up to m-1, then finishes.
// Trivial cases (square root of 0 or 1, small modulus, unused code) go
// straight to finish. After each word the block returns to idle, and only
// there takes the next one. All search arithmetic uses the single shared adder.
// Reset: synchronous on rst_n low; modulus returns to 2, no result pending.
// Stalls: out_stall holds the result word; the next item is still accepted
// while it waits, and a finished search waits in its final state.
// cfg_ready is low while a search runs or while an input word is offered.
module modular_search_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire msu_pkg::msu_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output msu_pkg::msu_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [msu_pkg::MSU_WIDTH-1:0] cfg_data
);

  import msu_pkg::*;

  localparam int BW = $clog2(MSU_WIDTH);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_SCANP  = 6'b000100,
    ST_SQTEST = 6'b001000,
    ST_SQSTEP = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [MSU_WIDTH-1:0] modulus_r;
  logic [MSU_WIDTH-1:0] value_r, value_nxt;
  logic                 target_r, target_nxt;   // residue sought by product scan
  logic [MSU_WIDTH-1:0] acc_r, acc_nxt;         // remainder, a*i mod m or i*i mod m
  logic [MSU_WIDTH-1:0] aux_r, aux_nxt;         // a mod m, or (2i+1) mod m
  logic [MSU_WIDTH-1:0] cnt_r, cnt_nxt;         // candidate i
  logic [BW-1:0]        bit_r, bit_nxt;         // operand bit under reduction
  logic [MSU_WIDTH-1:0] ans_r, ans_nxt;
  logic                 fnd_r, fnd_nxt;
  logic                 out_valid_r;
  msu_out_t             out_data_r;

  logic [MSU_WIDTH-1:0] u_x, u_y, u_sum;
  logic                 u_cin;
  logic [MSU_WIDTH-1:0] m_last;
  logic [MSU_WIDTH-1:0] sq_s0, sq_d0;
  logic                 in_take, out_take, out_load;

  // Shared modular adder: the one modular arithmetic unit of the sequencer.
  msu_addmod #(.WIDTH(MSU_WIDTH)) u_addmod (
    .x       (u_x),
    .y       (u_y),
    .cin     (u_cin),
    .m       (modulus_r),
    .sum_mod (u_sum)
  );

  assign in_stall  = (state_r != ST_IDLE);
  // Keep a modulus write off the edge that takes an input word.
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign m_last = modulus_r - MSU_WIDTH'(1);

  // Start of the square scan at i = 2: 4 mod m and 5 mod m for m >= 3.
  always_comb begin
    sq_s0 = MSU_WIDTH'(4);
    sq_d0 = MSU_WIDTH'(5);
    if (modulus_r == MSU_WIDTH'(3)) begin
      sq_s0 = MSU_WIDTH'(1);
      sq_d0 = MSU_WIDTH'(2);
    end else if (modulus_r == MSU_WIDTH'(4)) begin
      sq_s0 = MSU_WIDTH'(0);
      sq_d0 = MSU_WIDTH'(1);
    end else if (modulus_r == MSU_WIDTH'(5)) begin
      sq_d0 = MSU_WIDTH'(0);
    end
  end

  // Operand select for the shared adder.
  always_comb begin
    u_x   = acc_r;
    u_y   = aux_r;
    u_cin = 1'b0;
    case (state_r)
      ST_REDUCE: begin
        // Shift the remainder left and bring down the next operand bit.
        u_y   = acc_r;
        u_cin = value_r[bit_r];
      end
      ST_SQSTEP: begin
        u_x = aux_r;
        u_y = MSU_WIDTH'(2);
      end
      default: begin
        u_x = acc_r;
        u_y = aux_r;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    value_nxt  = value_r;
    target_nxt = target_r;
    acc_nxt    = acc_r;
    aux_nxt    = aux_r;
    cnt_nxt    = cnt_r;
    bit_nxt    = bit_r;
    ans_nxt    = ans_r;
    fnd_nxt    = fnd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          value_nxt  = in_data.value;
          target_nxt = (in_data.operation == OP_INVERSE);
          ans_nxt    = '0;
          fnd_nxt    = 1'b0;
          state_nxt  = ST_FINISH;
          case (in_data.operation)
            OP_INVERSE, OP_ZERODIV: begin
              if (modulus_r >= MSU_WIDTH'(2)) begin
                acc_nxt   = '0;
                bit_nxt   = BW'(MSU_WIDTH - 1);
                state_nxt = ST_REDUCE;
              end
            end
            OP_SQRT: begin
              if (in_data.value == MSU_WIDTH'(0)) begin
                fnd_nxt = 1'b1;
              end else if (in_data.value == MSU_WIDTH'(1)) begin
                ans_nxt = MSU_WIDTH'(1);
                fnd_nxt = 1'b1;
              end else if (modulus_r >= MSU_WIDTH'(3)) begin
                cnt_nxt   = MSU_WIDTH'(2);
                acc_nxt   = sq_s0;
                aux_nxt   = sq_d0;
                state_nxt = ST_SQTEST;
              end
            end
            default: begin
              fnd_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_REDUCE: begin
        acc_nxt = u_sum;
        if (bit_r == BW'(0)) begin
          aux_nxt   = u_sum;
          cnt_nxt   = MSU_WIDTH'(1);
          state_nxt = ST_SCANP;
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      ST_SCANP: begin
        if (acc_r == {{(MSU_WIDTH-1){1'b0}}, target_r}) begin
          ans_nxt   = cnt_r;
          fnd_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (cnt_r == m_last) begin
          state_nxt = ST_FINISH;
        end else begin
          acc_nxt = u_sum;
          cnt_nxt = cnt_r + MSU_WIDTH'(1);
        end
      end
      ST_SQTEST: begin
        if (acc_r == value_r) begin
          ans_nxt   = cnt_r;
          fnd_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (cnt_r == m_last) begin
          state_nxt = ST_FINISH;
        end else begin
          // (i+1)^2 = i^2 + (2i+1)
          acc_nxt   = u_sum;
          cnt_nxt   = cnt_r + MSU_WIDTH'(1);
          state_nxt = ST_SQSTEP;
        end
      end
      ST_SQSTEP: begin
        // Advance the odd step to 2(i+1)+1.
        aux_nxt   = u_sum;
        state_nxt = ST_SQTEST;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MSU_WIDTH'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    target_r <= target_nxt;
    acc_r    <= acc_nxt;
    aux_r    <= aux_nxt;
    cnt_r    <= cnt_nxt;
    bit_r    <= bit_nxt;
    ans_r    <= ans_nxt;
    fnd_r    <= fnd_nxt;
    if (out_load) begin
      out_data_r.answer <= ans_r;
      out_data_r.found  <= fnd_r;
    end
  end

`ifndef SYNTH
  // A failed search must report a zero answer.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.found || (out_data_r.answer == '0)))
    else $error("result without found flag carries nonzero answer");

  // Residues stay reduced below the modulus throughout a scan.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCANP || state_r == ST_SQTEST || state_r == ST_SQSTEP)
    |-> (acc_r < modulus_r && aux_r < modulus_r))
    else $error("scan residue not reduced");

  // An accepted word always starts work; the block never drops it back to idle.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != ST_IDLE))
    else $error("accepted word did not start a search");

  // The candidate counter never passes the last candidate below m.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCANP || state_r == ST_SQTEST) |-> (cnt_r < modulus_r))
    else $error("candidate beyond modulus");
`endif

endmodule

`default_nettype wire
